FILE: rtl/core/hpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hpi_pkg;

  localparam int FRAC_BITS = 16;
  // search abscissa: wide enough for centre +/- semi-axis and the right bounds
  localparam int XW = 34;
  localparam int DW = 33;
  localparam int SATW = 36;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] TOL_RESET = 16'd655;
  localparam logic [30:0] RLIM_RESET = 31'd2162688;
  localparam logic [30:0] RLIM_BH_RESET = 31'd2097152;
  localparam logic signed [XW-1:0] LEFT_BOUND = -(XW'(1) << FRAC_BITS);

  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_RIGHT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RIGHT_LIMIT_BH = 2'd2;

  typedef struct packed {
    logic signed [31:0] h;
    logic signed [31:0] k;
    logic signed [31:0] a;
    logic signed [47:0] b2;
    logic               hor;
  } hyper_t;

  typedef struct packed {
    hyper_t              first;
    hyper_t              second;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic                p1;
    logic                p2;
    logic                last;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic signed [XW-1:0] x;
    logic                 pos;
    hyper_t               hyp;
  } solve_req_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic signed [31:0] y;
  } solve_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(SATW'(32'h7FFF_FFFF))) r = 32'sh7FFF_FFFF;
    else if (v < -$signed(SATW'(33'h0_8000_0000))) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic opposite(input logic signed [DW-1:0] u,
                                    input logic signed [DW-1:0] v);
    return ((u < 0) && (v > 0)) || ((u > 0) && (v < 0));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hyperbola_pair_intersection_top.sv
// Work: one search word takes about (4 + 2 * steps) curve evaluations, each at most
// a long division, a fraction division for horizontal curves and a square root;
// steps is near log2(interval / tolerance). A pair gives 4 or 8 words.
// Throughput: one pair every 4 or 8 searches, set by the single shared evaluation unit.
// Reset: synchronous, active high; clears control state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module hyperbola_pair_intersection_top #(
  parameter int QUEUE_DEPTH = hpi_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] first_center_x,
  input  wire logic signed [31:0] first_center_y,
  input  wire logic signed [31:0] first_semi_axis,
  input  wire logic signed [47:0] first_conj_squared,
  input  wire logic               first_is_horizontal,
  input  wire logic signed [31:0] second_center_x,
  input  wire logic signed [31:0] second_center_y,
  input  wire logic signed [31:0] second_semi_axis,
  input  wire logic signed [47:0] second_conj_squared,
  input  wire logic               second_is_horizontal,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic                    point_y_valid,
  output logic                    last,
  input  wire logic               cfg_write_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  logic [15:0] tolerance;
  logic [30:0] right_limit, right_limit_bh;
  hpi_pkg::hyper_t first_in, second_in;
  hpi_pkg::job_t q_din, q_dout;
  logic q_push, q_full, q_pop, q_empty;
  hpi_pkg::solve_req_t sreq;
  hpi_pkg::solve_rsp_t srsp;

  always_comb begin
    first_in.h = first_center_x;
    first_in.k = first_center_y;
    first_in.a = first_semi_axis;
    first_in.b2 = first_conj_squared;
    first_in.hor = first_is_horizontal;
    second_in.h = second_center_x;
    second_in.k = second_center_y;
    second_in.a = second_semi_axis;
    second_in.b2 = second_conj_squared;
    second_in.hor = second_is_horizontal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= hpi_pkg::TOL_RESET;
      right_limit <= hpi_pkg::RLIM_RESET;
      right_limit_bh <= hpi_pkg::RLIM_BH_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        hpi_pkg::CFG_TOLERANCE:     tolerance <= cfg_data[15:0];
        hpi_pkg::CFG_RIGHT_LIMIT:   right_limit <= cfg_data;
        hpi_pkg::CFG_RIGHT_LIMIT_BH: right_limit_bh <= cfg_data;
        default: ;
      endcase
    end
  end

  hpi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_in       (first_in),
    .second_in      (second_in),
    .right_limit    (right_limit),
    .right_limit_bh (right_limit_bh),
    .full           (q_full),
    .push           (q_push),
    .job            (q_din)
  );

  hpi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  hpi_solve u_solve (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  hpi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tolerance     (tolerance),
    .empty         (q_empty),
    .job           (q_dout),
    .pop           (q_pop),
    .sreq          (sreq),
    .srsp          (srsp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_y_valid (point_y_valid),
    .last          (last)
  );

endmodule
`default_nettype wire

FILE: rtl/core/hpi_solve.sv
`timescale 1ns / 1ps
`default_nettype none
module hpi_solve (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hpi_pkg::solve_req_t req,
  output hpi_pkg::solve_rsp_t      rsp
);

  localparam int F = hpi_pkg::FRAC_BITS;
  localparam int XW = hpi_pkg::XW;
  localparam int SATW = hpi_pkg::SATW;

  typedef enum logic [9:0] {
    SV_IDLE = 10'b0000000001,
    SV_SQ   = 10'b0000000010,
    SV_A2   = 10'b0000000100,
    SV_CHK  = 10'b0000001000,
    SV_MUL  = 10'b0000010000,
    SV_DIV  = 10'b0000100000,
    SV_POST = 10'b0001000000,
    SV_DIV2 = 10'b0010000000,
    SV_ROOT = 10'b0100000000,
    SV_OUT  = 10'b1000000000
  } sv_state_t;

  sv_state_t st;
  hpi_pkg::hyper_t hyp;
  logic pos;
  logic ok;
  logic [31:0] xmag, amag, sq;
  logic [47:0] bmag;
  logic [63:0] s_sq, a_sq, mop_a, mop_b, pp, dvs, rem;
  logic [63:0] sv, sres, sbit;
  logic [127:0] acc, dq;
  logic [F-1:0] q2;
  logic [6:0] cnt;

  // operand magnitudes at capture
  logic signed [SATW-1:0] xd;
  logic signed [31:0] xh;
  logic [32:0] xh_ext, a_ext;
  logic [48:0] b_ext;
  logic [31:0] xmag_in, amag_in;
  logic [47:0] bmag_in;

  always_comb begin
    xd = $signed({{(SATW-XW){req.x[XW-1]}}, req.x})
       - $signed({{(SATW-32){req.hyp.h[31]}}, req.hyp.h});
    xh = hpi_pkg::sat32(xd);
    xh_ext = {xh[31], xh};
    a_ext = {req.hyp.a[31], req.hyp.a};
    b_ext = {req.hyp.b2[47], req.hyp.b2};
    xmag_in = xh[31] ? 32'(-xh_ext) : xh;
    amag_in = req.hyp.a[31] ? 32'(-a_ext) : req.hyp.a;
    bmag_in = req.hyp.b2[47] ? 48'(-b_ext) : req.hyp.b2;
  end

  // shared 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [1:0] pk;
  logic [127:0] ppw, acc_sum;

  always_comb begin
    ma = xmag;
    mb = xmag;
    if (st == SV_A2) begin
      ma = amag;
      mb = amag;
    end else if (st == SV_MUL) begin
      ma = cnt[1] ? mop_a[63:32] : mop_a[31:0];
      mb = cnt[0] ? mop_b[63:32] : mop_b[31:0];
    end
    mp = ma * mb;
    pk = cnt[1:0] - 2'd1;
    unique case (pk)
      2'd0:    ppw = {64'b0, pp};
      2'd3:    ppw = {pp, 64'b0};
      default: ppw = {32'b0, pp, 32'b0};
    endcase
    acc_sum = acc + ppw;
  end

  // classification terms
  logic [64:0] ds;
  logic dneg;
  logic [63:0] dmag;
  logic [111:0] bsh;
  logic phi_zero;

  always_comb begin
    ds = {1'b0, s_sq} - {1'b0, a_sq};
    dneg = ds[64];
    dmag = dneg ? 64'(-ds) : ds[63:0];
    bsh = {64'b0, bmag} << F;
    phi_zero = (bsh[111:64] == '0);
  end

  // restoring divider step, one quotient bit a cycle
  logic din, ge;
  logic [64:0] rs;
  logic [63:0] rnext;

  always_comb begin
    din = (st == SV_DIV) ? dq[127] : 1'b0;
    rs = {rem, din};
    ge = rs >= {1'b0, dvs};
    rnext = ge ? 64'(rs - {1'b0, dvs}) : rs[63:0];
  end

  // quotient checks after the long division
  logic q_over, t_over;
  logic [63:0] tlo;
  logic [64:0] vsum;

  always_comb begin
    q_over = |dq[127:64-F];
    t_over = |dq[127:64+F];
    tlo = dq[63+F:F];
    vsum = {1'b0, a_sq} + {1'b0, tlo};
  end

  // square root step, one result bit a cycle
  logic [63:0] trial, sres_n, sv_n;
  logic sge;

  always_comb begin
    trial = sres + sbit;
    sge = sv >= trial;
    sres_n = sge ? (sres >> 1) + sbit : sres >> 1;
    sv_n = sge ? sv - trial : sv;
  end

  logic signed [SATW-1:0] ys, k_ext, sq_ext;

  always_comb begin
    k_ext = $signed({{(SATW-32){hyp.k[31]}}, hyp.k});
    sq_ext = $signed({{(SATW-32){1'b0}}, sq});
    ys = pos ? k_ext + sq_ext : k_ext - sq_ext;
    rsp.done = (st == SV_OUT);
    rsp.ok = ok;
    rsp.y = hpi_pkg::sat32(ys);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SV_IDLE;
    end else begin
      unique case (st)
        SV_IDLE: begin
          if (req.start) begin
            hyp <= req.hyp;
            pos <= req.pos;
            xmag <= xmag_in;
            amag <= amag_in;
            bmag <= bmag_in;
            st <= SV_SQ;
          end
        end
        SV_SQ: begin
          s_sq <= mp;
          st <= SV_A2;
        end
        SV_A2: begin
          a_sq <= mp;
          st <= SV_CHK;
        end
        SV_CHK: begin
          acc <= '0;
          cnt <= '0;
          ok <= 1'b1;
          sq <= '0;
          if (hyp.hor) begin
            priority if (a_sq == '0) begin
              ok <= 1'b0;
              st <= SV_OUT;
            end else if ((bmag == '0) || (ds == '0)) begin
              st <= SV_OUT;
            end else if (hyp.b2[47] != dneg) begin
              ok <= 1'b0;
              st <= SV_OUT;
            end else begin
              mop_a <= 64'(bmag);
              mop_b <= dmag;
              dvs <= a_sq;
              st <= SV_MUL;
            end
          end else begin
            priority if (bmag == '0) begin
              ok <= 1'b0;
              st <= SV_OUT;
            end else if (hyp.b2[47] && phi_zero && (s_sq > bsh[63:0])) begin
              ok <= 1'b0;
              st <= SV_OUT;
            end else begin
              mop_a <= a_sq;
              mop_b <= s_sq;
              dvs <= 64'(bmag);
              st <= SV_MUL;
            end
          end
        end
        SV_MUL: begin
          if (cnt != '0) acc <= acc_sum;
          pp <= mp;
          if (cnt == 7'd4) begin
            dq <= acc_sum;
            rem <= '0;
            cnt <= '0;
            st <= SV_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        SV_DIV: begin
          rem <= rnext;
          dq <= {dq[126:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) st <= SV_POST;
        end
        SV_POST: begin
          cnt <= '0;
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
          if (hyp.hor) begin
            if (q_over) begin
              sq <= 32'hFFFF_FFFF;
              st <= SV_OUT;
            end else begin
              st <= SV_DIV2;
            end
          end else if (!hyp.b2[47]) begin
            if (t_over || vsum[64]) begin
              sq <= 32'hFFFF_FFFF;
              st <= SV_OUT;
            end else begin
              sv <= vsum[63:0];
              st <= SV_ROOT;
            end
          end else begin
            if (t_over || (tlo > a_sq)) begin
              sq <= '0;
              st <= SV_OUT;
            end else begin
              sv <= a_sq - tlo;
              st <= SV_ROOT;
            end
          end
        end
        SV_DIV2: begin
          rem <= rnext;
          q2 <= {q2[F-2:0], ge};
          if (cnt == 7'(F - 1)) begin
            sv <= {dq[63-F:0], q2[F-2:0], ge};
            cnt <= '0;
            st <= SV_ROOT;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        SV_ROOT: begin
          sv <= sv_n;
          sres <= sres_n;
          sbit <= sbit >> 2;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            sq <= sres_n[31:0];
            st <= SV_OUT;
          end
        end
        SV_OUT: st <= SV_IDLE;
        default: st <= SV_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hpi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hpi_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hpi_pkg::hyper_t first_in,
  input  wire hpi_pkg::hyper_t second_in,
  input  wire logic [30:0]     right_limit,
  input  wire logic [30:0]     right_limit_bh,
  input  wire logic            full,
  output logic                 push,
  output hpi_pkg::job_t        job
);

  localparam int XW = hpi_pkg::XW;

  logic busy;
  logic [2:0] j;
  hpi_pkg::hyper_t f, s, wide;
  logic both_hor, none_hor;
  logic [1:0] idx;
  logic signed [XW-1:0] u, l, rlim;

  always_comb begin
    both_hor = f.hor && s.hor;
    none_hor = !f.hor && !s.hor;
    if (both_hor) wide = (f.a >= s.a) ? f : s;
    else wide = f.hor ? f : s;
    u = $signed({{(XW-32){wide.h[31]}}, wide.h}) - $signed({{(XW-32){wide.a[31]}}, wide.a});
    l = $signed({{(XW-32){wide.h[31]}}, wide.h}) + $signed({{(XW-32){wide.a[31]}}, wide.a});
    rlim = $signed({{(XW-31){1'b0}}, both_hor ? right_limit_bh : right_limit});
    idx = none_hor ? j[1:0] : j[2:1];
    job.first = f;
    job.second = s;
    job.p1 = !idx[1];
    job.p2 = !idx[0];
    job.last = none_hor ? (j == 3'd3) : (j == 3'd7);
    if (none_hor) begin
      job.lo = hpi_pkg::LEFT_BOUND;
      job.hi = rlim;
    end else if (j[0]) begin
      job.lo = l;
      job.hi = rlim;
    end else begin
      job.lo = hpi_pkg::LEFT_BOUND;
      job.hi = u;
    end
    push = busy && !full;
    in_stall = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      j <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        f <= first_in;
        s <= second_in;
        j <= '0;
        busy <= 1'b1;
      end
    end else if (push) begin
      j <= j + 3'd1;
      // drop busy once the last search of the pair is queued
      if (job.last) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hpi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module hpi_queue #(
  parameter int DEPTH = hpi_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hpi_pkg::job_t  din,
  output logic                full,
  input  wire logic           pop,
  output hpi_pkg::job_t       dout,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hpi_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic do_push, do_pop;

  always_comb begin
    full = (cnt == CW'(DEPTH));
    empty = (cnt == '0);
    do_push = push && !full;
    do_pop = pop && !empty;
    dout = mem[rp];
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      if (do_pop) rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hpi_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hpi_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       tolerance,
  input  wire logic              empty,
  input  wire hpi_pkg::job_t     job,
  output logic                   pop,
  output hpi_pkg::solve_req_t    sreq,
  input  wire hpi_pkg::solve_rsp_t srsp,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   found,
  output logic signed [31:0]     point_x,
  output logic signed [31:0]     point_y,
  output logic                   point_y_valid,
  output logic                   last
);

  localparam int XW = hpi_pkg::XW;
  localparam int DW = hpi_pkg::DW;
  localparam int SATW = hpi_pkg::SATW;

  typedef enum logic [9:0] {
    BK_IDLE  = 10'b0000000001,
    BK_LO1   = 10'b0000000010,
    BK_LO2   = 10'b0000000100,
    BK_HI1   = 10'b0000001000,
    BK_HI2   = 10'b0000010000,
    BK_MID1  = 10'b0000100000,
    BK_MID2  = 10'b0001000000,
    BK_TEST  = 10'b0010000000,
    BK_FINAL = 10'b0100000000,
    BK_EMIT  = 10'b1000000000
  } bk_state_t;

  bk_state_t st;
  hpi_pkg::hyper_t f, s;
  logic signed [XW-1:0] lo, hi, c;
  logic p1, p2, job_last, pend;
  logic signed [31:0] y1, yc;
  logic ycv, fav;
  logic signed [DW-1:0] fa;
  logic r_found, r_yv;
  logic signed [31:0] r_x, r_y;

  logic [15:0] tol_eff;
  logic signed [XW:0] width, qwidth;
  logic wide_ok, qwide_ok;
  logic signed [XW-1:0] mid;
  logic in_solve, use_first;
  logic signed [DW-1:0] dy, dyc;
  logic load;

  always_comb begin
    tol_eff = (tolerance == '0) ? 16'd1 : tolerance;
    width = $signed({hi[XW-1], hi}) - $signed({lo[XW-1], lo});
    qwidth = $signed({job.hi[XW-1], job.hi}) - $signed({job.lo[XW-1], job.lo});
    wide_ok = width > $signed({{(XW+1-16){1'b0}}, tol_eff});
    qwide_ok = qwidth > $signed({{(XW+1-16){1'b0}}, tol_eff});
    mid = lo + $signed(width[XW:1]);
    dy = $signed({y1[31], y1}) - $signed({srsp.y[31], srsp.y});
    dyc = $signed({yc[31], yc}) - $signed({srsp.y[31], srsp.y});
    in_solve = (st == BK_LO1) || (st == BK_LO2) || (st == BK_HI1) || (st == BK_HI2)
            || (st == BK_MID1) || (st == BK_MID2);
    use_first = (st == BK_LO1) || (st == BK_HI1) || (st == BK_MID1);
    sreq.start = in_solve && !pend;
    sreq.pos = use_first ? p1 : p2;
    sreq.hyp = use_first ? f : s;
    if ((st == BK_LO1) || (st == BK_LO2)) sreq.x = lo;
    else if ((st == BK_HI1) || (st == BK_HI2)) sreq.x = hi;
    else sreq.x = c;
    pop = (st == BK_IDLE) && !empty;
    load = (st == BK_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sreq.start) pend <= 1'b1;
      else if (srsp.done) pend <= 1'b0;

      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (st)
        BK_IDLE: begin
          r_found <= 1'b0;
          r_x <= '0;
          r_y <= '0;
          r_yv <= 1'b0;
          if (!empty) begin
            f <= job.first;
            s <= job.second;
            lo <= job.lo;
            hi <= job.hi;
            p1 <= job.p1;
            p2 <= job.p2;
            job_last <= job.last;
            st <= qwide_ok ? BK_LO1 : BK_EMIT;
          end
        end
        BK_LO1, BK_HI1: begin
          if (srsp.done) begin
            y1 <= srsp.y;
            if (!srsp.ok) st <= BK_EMIT;
            else st <= (st == BK_LO1) ? BK_LO2 : BK_HI2;
          end
        end
        BK_LO2: begin
          if (srsp.done) begin
            fa <= dy;
            fav <= 1'b1;
            st <= srsp.ok ? BK_HI1 : BK_EMIT;
          end
        end
        BK_HI2: begin
          if (srsp.done) begin
            if (srsp.ok && hpi_pkg::opposite(fa, dy)) begin
              c <= mid;
              st <= BK_MID1;
            end else begin
              st <= BK_EMIT;
            end
          end
        end
        BK_MID1: begin
          if (srsp.done) begin
            yc <= srsp.y;
            ycv <= srsp.ok;
            if (!srsp.ok) begin
              // midpoint invalid: advance the left bound
              lo <= c;
              fav <= 1'b0;
              st <= BK_TEST;
            end else begin
              st <= BK_MID2;
            end
          end
        end
        BK_MID2: begin
          if (srsp.done) begin
            priority if (!srsp.ok || !fav) begin
              lo <= c;
              fav <= srsp.ok;
              fa <= dyc;
              st <= BK_TEST;
            end else if (dyc == '0) begin
              st <= BK_FINAL;
            end else if (hpi_pkg::opposite(dyc, fa)) begin
              hi <= c;
              st <= BK_TEST;
            end else begin
              lo <= c;
              fa <= dyc;
              st <= BK_TEST;
            end
          end
        end
        BK_TEST: begin
          if (wide_ok) begin
            c <= mid;
            st <= BK_MID1;
          end else begin
            st <= BK_FINAL;
          end
        end
        BK_FINAL: begin
          r_found <= 1'b1;
          r_x <= hpi_pkg::sat32($signed({{(SATW-XW){c[XW-1]}}, c}));
          r_y <= ycv ? yc : '0;
          r_yv <= ycv;
          st <= BK_EMIT;
        end
        BK_EMIT: begin
          if (load) st <= BK_IDLE;
        end
        default: st <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found <= r_found;
      point_x <= r_x;
      point_y <= r_y;
      point_y_valid <= r_yv;
      last <= job_last;
    end
  end

endmodule
`default_nettype wire
